[rtl/core/mpxr_pkg.sv]
`timescale 1ns / 1ps

package mpxr_pkg;

    // sizing
    localparam int KEY_BYTES  = 32;
    localparam int MAX_PASSES = 16;
    localparam int KIDX_W     = $clog2(KEY_BYTES);
    localparam int KLEN_W     = KIDX_W + 1;
    localparam int PIDX_W     = $clog2(MAX_PASSES);
    localparam int PCNT_W     = 5;
    localparam int MLEN_W     = 32;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int DEF_PASSES = 3;

    // round constants
    localparam logic [7:0] PASS_MUL = 8'h1B;
    localparam logic [7:0] PASS_ADD = 8'h5A;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0     = 3'd0,
        REG_KEY1     = 3'd1,
        REG_KEY2     = 3'd2,
        REG_KEY3     = 3'd3,
        REG_KEY_LEN  = 3'd4,
        REG_MSG_LEN  = 3'd5,
        REG_PASS_CNT = 3'd6,
        REG_DECRYPT  = 3'd7
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_N,
        ST_MOD_I,
        ST_OFFS,
        ST_RUN,
        ST_DONE
    } state_t;

    // control for one round
    typedef struct packed {
        logic              decrypt;
        logic [PIDX_W-1:0] pass_idx;
    } round_ctl_t;

    // whitening constant of one pass
    function automatic logic [7:0] round_whiten(input logic [PIDX_W-1:0] p);
        logic [7:0] prod;
        begin
            prod = 8'(p) * PASS_MUL;
            return prod + PASS_ADD;
        end
    endfunction

    // modular add, both operands below k
    function automatic logic [KIDX_W-1:0] add_mod(input logic [KIDX_W-1:0] a,
                                                  input logic [KIDX_W-1:0] b,
                                                  input logic [KLEN_W-1:0] k);
        logic [KLEN_W-1:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= k) begin
                s = s - k;
            end
            return s[KIDX_W-1:0];
        end
    endfunction

    // modular subtract, both operands below k
    function automatic logic [KIDX_W-1:0] sub_mod(input logic [KIDX_W-1:0] a,
                                                  input logic [KIDX_W-1:0] b,
                                                  input logic [KLEN_W-1:0] k);
        logic [KLEN_W-1:0] s;
        begin
            if (a >= b) begin
                s = {1'b0, a} - {1'b0, b};
            end else begin
                s = {1'b0, a} + k - {1'b0, b};
            end
            return s[KIDX_W-1:0];
        end
    endfunction

    // one restoring step of a remainder by k
    function automatic logic [KIDX_W-1:0] mod_step(input logic [KIDX_W-1:0] r,
                                                   input logic              bit_in,
                                                   input logic [KLEN_W-1:0] k);
        logic [KLEN_W-1:0] t;
        begin
            t = {r, bit_in};
            if (t >= k) begin
                t = t - k;
            end
            return t[KIDX_W-1:0];
        end
    endfunction

endpackage

[rtl/core/multi_pass_xor_rotate_cipher_core.sv]
`timescale 1ns / 1ps

// Multi-pass XOR-rotate byte cipher.
// Input channel s_valid/s_ready/s_data_in takes one message byte per word;
// output channel m_valid/m_ready carries m_data_out and m_last_of_message,
// which is set on the byte that closes a message of message_length bytes.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (keys,
// key_length, message_length, pass_count, decrypt_mode); write only when idle.
// Each byte is accepted, run through its passes on the shared round unit,
// one pass per cycle, and handed off to the output register; P is the pass
// count in effect (3 when zero, at most 16). A new byte is taken only once
// the previous one has been handed off to the output register.
// After reset, and after a write of key_length, message_length or pass_count,
// a setup sequence runs before the next byte is taken: a start step, two
// 32-step remainders by the key length, P - 1 modular adds and a closing
// step.
// Reset clears the byte position, keys to zero and lengths to one.
// When the receiver stalls, the finished byte waits in the output register;
// the next byte may already be accepted and computed, then holds until the
// output register frees up.
module multi_pass_xor_rotate_cipher_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mpxr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpxr_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_data_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_data_out,
    output logic                            m_last_of_message
);
    import mpxr_pkg::*;

    // configuration registers
    logic [7:0]        key_reg [KEY_BYTES];
    logic [KLEN_W-1:0] key_len_reg;
    logic [MLEN_W-1:0] msg_len_reg;
    logic [PCNT_W-1:0] pass_cnt_reg;
    logic              dec_reg;

    // sequencer state
    state_t            state_reg, state_next;
    logic              dirty_reg, dirty_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [MLEN_W-1:0] sh_reg, sh_next;
    logic [KIDX_W-1:0] rem_reg, rem_next;
    logic [KIDX_W-1:0] nmk_reg, nmk_next;
    logic [KIDX_W-1:0] pmk_reg, pmk_next;
    logic [KIDX_W-1:0] top_reg, top_next;
    logic [MLEN_W-1:0] pos_reg, pos_next;
    logic [7:0]        work_reg, work_next;
    logic [PIDX_W-1:0] pidx_reg, pidx_next;
    logic [KIDX_W-1:0] kidx_reg, kidx_next;
    logic              dec_run_reg, dec_run_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    // effective settings
    logic [KLEN_W-1:0] k_eff;
    logic [MLEN_W-1:0] n_eff;
    logic [PCNT_W-1:0] passes_eff;
    logic [PIDX_W-1:0] last_pidx;
    logic [MLEN_W:0]   pos_inc;
    logic              pos_last;
    logic [KLEN_W-1:0] pmk_inc;
    logic              cfg_setup_hit;
    logic              accept;

    round_ctl_t        round_ctl;
    logic [7:0]        round_out;

    always_comb begin
        if (key_len_reg == '0) begin
            k_eff = KLEN_W'(1);
        end else if (key_len_reg > KLEN_W'(KEY_BYTES)) begin
            k_eff = KLEN_W'(KEY_BYTES);
        end else begin
            k_eff = key_len_reg;
        end
        n_eff = (msg_len_reg == '0) ? MLEN_W'(1) : msg_len_reg;
        if (pass_cnt_reg == '0) begin
            passes_eff = PCNT_W'(DEF_PASSES);
        end else if (pass_cnt_reg > PCNT_W'(MAX_PASSES)) begin
            passes_eff = PCNT_W'(MAX_PASSES);
        end else begin
            passes_eff = pass_cnt_reg;
        end
    end

    assign last_pidx = PIDX_W'(passes_eff - PCNT_W'(1));
    assign pos_inc   = {1'b0, pos_reg} + (MLEN_W + 1)'(1);
    assign pos_last  = pos_inc >= {1'b0, n_eff};
    assign pmk_inc   = {1'b0, pmk_reg} + KLEN_W'(1);

    assign cfg_setup_hit = cfg_we
                           && (cfg_index inside {REG_KEY_LEN, REG_MSG_LEN, REG_PASS_CNT});

    assign s_ready = (state_reg == ST_IDLE) && !dirty_reg;
    assign accept  = s_valid && s_ready;

    // shared round unit
    assign round_ctl.decrypt  = dec_run_reg;
    assign round_ctl.pass_idx = pidx_reg;

    mpxr_round u_round (
        .data_i     (work_reg),
        .key_byte_i (key_reg[kidx_reg]),
        .ctl_i      (round_ctl),
        .data_o     (round_out)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < KEY_BYTES; b++) begin
                key_reg[b] <= '0;
            end
            key_len_reg  <= KLEN_W'(1);
            msg_len_reg  <= MLEN_W'(1);
            pass_cnt_reg <= '0;
            dec_reg      <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
                    for (int j = 0; j < 8; j++) begin
                        if ((int'(cfg_index) * 8 + j) < KEY_BYTES) begin
                            key_reg[KIDX_W'(int'(cfg_index) * 8 + j)] <= cfg_wdata[8*j +: 8];
                        end
                    end
                end
                REG_KEY_LEN:  key_len_reg  <= cfg_wdata[KLEN_W-1:0];
                REG_MSG_LEN:  msg_len_reg  <= cfg_wdata[MLEN_W-1:0];
                REG_PASS_CNT: pass_cnt_reg <= cfg_wdata[PCNT_W-1:0];
                REG_DECRYPT:  dec_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dirty_reg     <= 1'b1;
            cnt_reg       <= '0;
            nmk_reg       <= '0;
            pmk_reg       <= '0;
            top_reg       <= '0;
            pos_reg       <= '0;
            pidx_reg      <= '0;
            kidx_reg      <= '0;
            dec_run_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            dirty_reg     <= dirty_next;
            cnt_reg       <= cnt_next;
            nmk_reg       <= nmk_next;
            pmk_reg       <= pmk_next;
            top_reg       <= top_next;
            pos_reg       <= pos_next;
            pidx_reg      <= pidx_next;
            kidx_reg      <= kidx_next;
            dec_run_reg   <= dec_run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        sh_reg       <= sh_next;
        rem_reg      <= rem_next;
        work_reg     <= work_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // next state and datapath control
    always_comb begin
        state_next     = state_reg;
        dirty_next     = dirty_reg;
        cnt_next       = cnt_reg;
        sh_next        = sh_reg;
        rem_next       = rem_reg;
        nmk_next       = nmk_reg;
        pmk_next       = pmk_reg;
        top_next       = top_reg;
        pos_next       = pos_reg;
        work_next      = work_reg;
        pidx_next      = pidx_reg;
        kidx_next      = kidx_reg;
        dec_run_next   = dec_run_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (dirty_reg) begin
                    // start setup with message length mod key length
                    sh_next    = n_eff;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_MOD_N;
                end else if (accept) begin
                    work_next    = s_data_in;
                    dec_run_next = dec_reg;
                    last_next    = pos_last;
                    if (dec_reg) begin
                        pidx_next = last_pidx;
                        kidx_next = add_mod(pmk_reg, top_reg, k_eff);
                    end else begin
                        pidx_next = '0;
                        kidx_next = pmk_reg;
                    end
                    // advance position and its residue
                    if (pos_last) begin
                        pos_next = '0;
                        pmk_next = '0;
                    end else begin
                        pos_next = pos_inc[MLEN_W-1:0];
                        pmk_next = (pmk_inc == k_eff) ? '0 : pmk_inc[KIDX_W-1:0];
                    end
                    state_next = ST_RUN;
                end
            end

            ST_MOD_N: begin
                rem_next = mod_step(rem_reg, sh_reg[MLEN_W-1], k_eff);
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    nmk_next   = mod_step(rem_reg, sh_reg[MLEN_W-1], k_eff);
                    sh_next    = pos_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_MOD_I;
                end
            end

            ST_MOD_I: begin
                rem_next = mod_step(rem_reg, sh_reg[MLEN_W-1], k_eff);
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    pmk_next   = mod_step(rem_reg, sh_reg[MLEN_W-1], k_eff);
                    top_next   = '0;
                    cnt_next   = 5'(last_pidx);
                    state_next = ST_OFFS;
                end
            end

            // key offset of the top pass
            ST_OFFS: begin
                if (cnt_reg == '0) begin
                    dirty_next = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    top_next = add_mod(top_reg, nmk_reg, k_eff);
                    cnt_next = cnt_reg - 5'd1;
                end
            end

            // one pass per cycle
            ST_RUN: begin
                work_next = round_out;
                if (dec_run_reg) begin
                    kidx_next = sub_mod(kidx_reg, nmk_reg, k_eff);
                    pidx_next = pidx_reg - PIDX_W'(1);
                    if (pidx_reg == '0) begin
                        state_next = ST_DONE;
                    end
                end else begin
                    kidx_next = add_mod(kidx_reg, nmk_reg, k_eff);
                    pidx_next = pidx_reg + PIDX_W'(1);
                    if (pidx_reg == last_pidx) begin
                        state_next = ST_DONE;
                    end
                end
            end

            // hand off to the output register
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = work_reg;
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // setup values changed: redo setup, also when it is just starting
        if (cfg_setup_hit) begin
            dirty_next = 1'b1;
            if ((state_reg inside {ST_MOD_N, ST_MOD_I, ST_OFFS})
                || (state_reg == ST_IDLE && dirty_reg)) begin
                state_next = ST_IDLE;
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_data_out        = out_data_reg;
    assign m_last_of_message = out_last_reg;

endmodule

[rtl/core/mpxr_round.sv]
`timescale 1ns / 1ps

module mpxr_round (
    input  logic [7:0]               data_i,
    input  logic [7:0]               key_byte_i,
    input  mpxr_pkg::round_ctl_t     ctl_i,
    output logic [7:0]               data_o
);
    import mpxr_pkg::*;

    logic [2:0]  rot_amt;
    logic [7:0]  pc;
    logic [7:0]  enc_pre;
    logic [7:0]  dec_pre;
    logic [15:0] enc_rot;
    logic [15:0] dec_rot;

    // rotate amount and whitening constant for this pass
    assign rot_amt = 3'(ctl_i.pass_idx + PIDX_W'(3));
    assign pc      = round_whiten(ctl_i.pass_idx);

    // forward: key, rotate left, constant
    assign enc_pre = data_i ^ key_byte_i;
    assign enc_rot = {enc_pre, enc_pre} << rot_amt;

    // inverse: constant, rotate right, key
    assign dec_pre = data_i ^ pc;
    assign dec_rot = {dec_pre, dec_pre} >> rot_amt;

    assign data_o = ctl_i.decrypt ? (dec_rot[7:0] ^ key_byte_i) : (enc_rot[15:8] ^ pc);

endmodule
